@@ rtl/ps2mct_pkg.sv @@
// Package: payload types, constants and helpers for the PS/2 mouse cursor tracker.
package ps2mct_pkg;

    localparam int COORD_BITS    = 11;
    localparam int CURSOR_MARGIN = 16;
    localparam int CFG_BITS      = 11;
    localparam int SUM_BITS      = COORD_BITS + 2;

    localparam logic [COORD_BITS-1:0] SCREEN_WIDTH_RESET  = COORD_BITS'(1024);
    localparam logic [COORD_BITS-1:0] SCREEN_HEIGHT_RESET = COORD_BITS'(768);
    localparam logic [COORD_BITS-1:0] POS_X_RESET         = COORD_BITS'(512);
    localparam logic [COORD_BITS-1:0] POS_Y_RESET         = COORD_BITS'(384);

    localparam logic CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic CFG_SCREEN_HEIGHT = 1'b1;

    localparam logic REQ_DATA   = 1'b0;
    localparam logic REQ_REINIT = 1'b1;

    localparam int HDR_BUTTONS_LSB = 0;
    localparam int HDR_X_SIGN      = 4;
    localparam int HDR_Y_SIGN      = 5;

    typedef struct packed {
        logic       req_type;
        logic       from_mouse;
        logic [7:0] data_byte;
    } in_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] cursor_col;
        logic [COORD_BITS-1:0] cursor_y;
        logic [1:0]            button_bits;
        logic                  packet_done;
        logic                  key_valid;
        logic [7:0]            key_byte;
    } out_t;

    function automatic logic [COORD_BITS-1:0] clamp_limit(input logic [COORD_BITS-1:0] size);
        logic [COORD_BITS-1:0] margin;
        margin = COORD_BITS'(CURSOR_MARGIN);
        return (size < margin) ? '0 : (size - margin);
    endfunction

    function automatic logic [COORD_BITS-1:0] clamp_coord(
        input logic signed [SUM_BITS-1:0] v,
        input logic [COORD_BITS-1:0]      size
    );
        logic [COORD_BITS-1:0] limit;
        limit = clamp_limit(size);
        if (v[SUM_BITS-1])
            return '0;
        else if (v > $signed({2'b00, limit}))
            return limit;
        else
            return v[COORD_BITS-1:0];
    endfunction

endpackage

@@ rtl/ps2_mouse_cursor_tracker.sv @@
// PS/2 mouse cursor tracker: packet assembly, button and cursor update, reinit, key pass-through.
// An accepted transaction goes to the input register, then its result to the output register.
// Throughput: one transaction per cycle; the input register and the result register
// each advance whenever the stage after them is empty or being drained.
// Reset: asynchronous, active low; clears both stages, the packet byte count and buttons,
// sets the screen to 1024 x 768 and the cursor to 512, 384.
module ps2_mouse_cursor_tracker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  ps2mct_pkg::in_t                       in_data,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output ps2mct_pkg::out_t                      out_data,
    input  logic                                  cfg_we,
    input  logic                                  cfg_index,
    input  logic [ps2mct_pkg::CFG_BITS-1:0]       cfg_wdata
);

    localparam logic [1:0] BC_HEADER = 2'd0;
    localparam logic [1:0] BC_XDELTA = 2'd1;
    localparam logic [1:0] BC_YDELTA = 2'd2;

    localparam int CB = ps2mct_pkg::COORD_BITS;
    localparam int SB = ps2mct_pkg::SUM_BITS;

    logic                  s1_valid_reg;
    ps2mct_pkg::in_t       s1_data_reg;
    logic                  out_valid_reg;
    ps2mct_pkg::out_t      out_data_reg, out_data_next;

    logic [CB-1:0]         screen_width_reg, screen_height_reg;
    logic [1:0]            byte_count_reg, byte_count_next;
    logic [7:0]            header_byte_reg, header_byte_next;
    logic [7:0]            x_delta_byte_reg, x_delta_byte_next;
    logic [CB-1:0]         pos_x_reg, pos_x_next;
    logic [CB-1:0]         pos_y_reg, pos_y_next;
    logic [1:0]            buttons_held_reg, buttons_held_next;

    logic                  adv_out;
    logic                  take_in;
    logic signed [SB-1:0]  dx, dy, sum_x, sum_y;

    assign adv_out   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !adv_out;
    assign take_in   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign dx    = $signed({{(SB-8){header_byte_reg[ps2mct_pkg::HDR_X_SIGN]}}, x_delta_byte_reg});
    assign dy    = -$signed({{(SB-8){header_byte_reg[ps2mct_pkg::HDR_Y_SIGN]}},
                             s1_data_reg.data_byte});
    assign sum_x = $signed({2'b00, pos_x_reg}) + dx;
    assign sum_y = $signed({2'b00, pos_y_reg}) + dy;

    always_comb
    begin
        byte_count_next   = byte_count_reg;
        header_byte_next  = header_byte_reg;
        x_delta_byte_next = x_delta_byte_reg;
        pos_x_next        = pos_x_reg;
        pos_y_next        = pos_y_reg;
        buttons_held_next = buttons_held_reg;
        out_data_next     = '0;

        priority if (s1_data_reg.req_type == ps2mct_pkg::REQ_REINIT)
        begin
            byte_count_next = BC_HEADER;
            pos_x_next      = screen_width_reg >> 1;
            pos_y_next      = screen_height_reg >> 1;
        end
        else if (!s1_data_reg.from_mouse)
        begin
            out_data_next.key_valid = 1'b1;
            out_data_next.key_byte  = s1_data_reg.data_byte;
        end
        else
        begin
            unique case (byte_count_reg)
                BC_HEADER:
                begin
                    header_byte_next = s1_data_reg.data_byte;
                    byte_count_next  = BC_XDELTA;
                end
                BC_XDELTA:
                begin
                    x_delta_byte_next = s1_data_reg.data_byte;
                    byte_count_next   = BC_YDELTA;
                end
                default:
                begin
                    buttons_held_next = header_byte_reg[ps2mct_pkg::HDR_BUTTONS_LSB +: 2];
                    pos_x_next        = ps2mct_pkg::clamp_coord(sum_x, screen_width_reg);
                    pos_y_next        = ps2mct_pkg::clamp_coord(sum_y, screen_height_reg);
                    byte_count_next   = BC_HEADER;
                    out_data_next.packet_done = 1'b1;
                end
            endcase
        end

        out_data_next.cursor_col  = pos_x_next;
        out_data_next.cursor_y    = pos_y_next;
        out_data_next.button_bits = buttons_held_next;
    end

    // hold the configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= ps2mct_pkg::SCREEN_WIDTH_RESET;
            screen_height_reg <= ps2mct_pkg::SCREEN_HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == ps2mct_pkg::CFG_SCREEN_WIDTH)
                screen_width_reg <= cfg_wdata;
            else
                screen_height_reg <= cfg_wdata;
        end
    end

    // advance the pipeline and the decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            byte_count_reg   <= BC_HEADER;
            header_byte_reg  <= '0;
            x_delta_byte_reg <= '0;
            pos_x_reg        <= ps2mct_pkg::POS_X_RESET;
            pos_y_reg        <= ps2mct_pkg::POS_Y_RESET;
            buttons_held_reg <= '0;
        end
        else
        begin
            if (take_in)
                s1_valid_reg <= 1'b1;
            else if (adv_out)
                s1_valid_reg <= 1'b0;

            if (adv_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (adv_out)
            begin
                byte_count_reg   <= byte_count_next;
                header_byte_reg  <= header_byte_next;
                x_delta_byte_reg <= x_delta_byte_next;
                pos_x_reg        <= pos_x_next;
                pos_y_reg        <= pos_y_next;
                buttons_held_reg <= buttons_held_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
            s1_data_reg <= in_data;
        if (adv_out)
            out_data_reg <= out_data_next;
    end

`ifndef SYNTH
    a_byte_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg != 2'd3)
        else $error("packet byte count out of range");

    a_done_or_key: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_data_reg.packet_done && out_data_reg.key_valid))
        else $error("result marks both packet and key");

    a_key_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.key_valid) |-> (out_data_reg.key_byte == 8'd0))
        else $error("key byte set without key valid");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without a blocked result");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv_out |=> $stable(pos_x_reg) && $stable(pos_y_reg) && $stable(byte_count_reg))
        else $error("decoder state moved without a transaction");
`endif

endmodule
